>>> hdl/qslerp_pkg.sv
package qslerp_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int WB          = 30;
   localparam int ITERS       = 30;
   localparam int SQRT_STEPS  = 31;
   localparam int DIV_STEPS   = 31;
   localparam int THR_RESET   = 16382;

   localparam logic [30:0]        ONE30    = 31'h4000_0000;
   localparam logic signed [33:0] GAIN_INV = 34'sd652032874;

   typedef struct packed {
      logic [3:0][15:0] a;
      logic [3:0][16:0] b;
      logic [30:0]      t30;
      logic             use_lin;
      logic [30:0]      c30;
      logic [30:0]      s30;
   } side_type;

   function automatic logic [31:0] atan_val(input int idx);
      logic [31:0] r;
      case (idx)
         0:  r = 32'd843314857;
         1:  r = 32'd497837829;
         2:  r = 32'd263043837;
         3:  r = 32'd133525159;
         4:  r = 32'd67021687;
         5:  r = 32'd33543516;
         6:  r = 32'd16775851;
         7:  r = 32'd8388437;
         8:  r = 32'd4194283;
         9:  r = 32'd2097149;
         10: r = 32'd1048576;
         11: r = 32'd524288;
         12: r = 32'd262144;
         13: r = 32'd131072;
         14: r = 32'd65536;
         15: r = 32'd32768;
         16: r = 32'd16384;
         17: r = 32'd8192;
         18: r = 32'd4096;
         19: r = 32'd2048;
         20: r = 32'd1024;
         21: r = 32'd512;
         22: r = 32'd256;
         23: r = 32'd128;
         24: r = 32'd64;
         25: r = 32'd32;
         26: r = 32'd16;
         27: r = 32'd8;
         28: r = 32'd4;
         29: r = 32'd2;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/qslerp_isqrt.sv
module qslerp_isqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [60:0]          in_rad,
   input  qslerp_pkg::side_type in_side,
   output logic                 out_valid,
   output logic [30:0]          out_root,
   output qslerp_pkg::side_type out_side
);

   localparam int N = qslerp_pkg::SQRT_STEPS;

   logic [N-1:0]         valid_ff;
   logic [61:0]          v_ff   [N];
   logic [61:0]          res_ff [N];
   qslerp_pkg::side_type side_ff[N];

   for (genvar i = 0; i < N; i++) begin : g_step
      localparam logic [61:0] BITV = 62'(1) << (60 - 2 * i);
      logic [61:0] v_src, res_src, v_in, res_in, trial;
      logic        valid_src;
      qslerp_pkg::side_type side_src;

      if (i == 0) begin : g_first
         assign v_src     = {1'b0, in_rad};
         assign res_src   = '0;
         assign valid_src = in_valid;
         assign side_src  = in_side;
      end else begin : g_next
         assign v_src     = v_ff[i-1];
         assign res_src   = res_ff[i-1];
         assign valid_src = valid_ff[i-1];
         assign side_src  = side_ff[i-1];
      end

      always_comb begin
         trial = res_src + BITV;
         if (v_src >= trial) begin
            v_in   = v_src - trial;
            res_in = (res_src >> 1) + BITV;
         end else begin
            v_in   = v_src;
            res_in = res_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[i]    <= v_in;
            res_ff[i]  <= res_in;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = res_ff[N-1][30:0];
   assign out_side  = side_ff[N-1];

endmodule

>>> hdl/qslerp_cordic_vec.sv
module qslerp_cordic_vec (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [33:0]   in_x,
   input  logic signed [33:0]   in_y,
   input  qslerp_pkg::side_type in_side,
   output logic                 out_valid,
   output logic signed [32:0]   out_angle,
   output qslerp_pkg::side_type out_side
);

   localparam int N = qslerp_pkg::ITERS;

   logic [N-1:0]         valid_ff;
   logic signed [33:0]   x_ff [N];
   logic signed [33:0]   y_ff [N];
   logic signed [32:0]   z_ff [N];
   qslerp_pkg::side_type side_ff[N];

   for (genvar i = 0; i < N; i++) begin : g_step
      localparam logic signed [32:0] ANG = 33'(qslerp_pkg::atan_val(i));
      logic signed [33:0] x_src, y_src, x_in, y_in;
      logic signed [32:0] z_src, z_in;
      logic               valid_src;
      qslerp_pkg::side_type side_src;

      if (i == 0) begin : g_first
         assign x_src     = in_x;
         assign y_src     = in_y;
         assign z_src     = '0;
         assign valid_src = in_valid;
         assign side_src  = in_side;
      end else begin : g_next
         assign x_src     = x_ff[i-1];
         assign y_src     = y_ff[i-1];
         assign z_src     = z_ff[i-1];
         assign valid_src = valid_ff[i-1];
         assign side_src  = side_ff[i-1];
      end

      always_comb begin
         if (!y_src[33]) begin
            x_in = x_src + (y_src >>> i);
            y_in = y_src - (x_src >>> i);
            z_in = z_src + ANG;
         end else begin
            x_in = x_src - (y_src >>> i);
            y_in = y_src + (x_src >>> i);
            z_in = z_src - ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_angle = z_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

>>> hdl/qslerp_cordic_rot.sv
module qslerp_cordic_rot (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [33:0]   in_z0,
   input  logic signed [33:0]   in_z1,
   input  qslerp_pkg::side_type in_side,
   output logic                 out_valid,
   output logic signed [33:0]   out_sin0,
   output logic signed [33:0]   out_sin1,
   output qslerp_pkg::side_type out_side
);

   localparam int N = qslerp_pkg::ITERS;

   logic [N-1:0]         valid_ff;
   logic signed [33:0]   x_ff [N][2];
   logic signed [33:0]   y_ff [N][2];
   logic signed [33:0]   z_ff [N][2];
   qslerp_pkg::side_type side_ff[N];

   for (genvar i = 0; i < N; i++) begin : g_step
      localparam logic signed [33:0] ANG = 34'(qslerp_pkg::atan_val(i));
      logic signed [33:0] x_src [2];
      logic signed [33:0] y_src [2];
      logic signed [33:0] z_src [2];
      logic signed [33:0] x_in  [2];
      logic signed [33:0] y_in  [2];
      logic signed [33:0] z_in  [2];
      logic               valid_src;
      qslerp_pkg::side_type side_src;

      if (i == 0) begin : g_first
         assign x_src[0]  = qslerp_pkg::GAIN_INV;
         assign x_src[1]  = qslerp_pkg::GAIN_INV;
         assign y_src[0]  = '0;
         assign y_src[1]  = '0;
         assign z_src[0]  = in_z0;
         assign z_src[1]  = in_z1;
         assign valid_src = in_valid;
         assign side_src  = in_side;
      end else begin : g_next
         assign x_src[0]  = x_ff[i-1][0];
         assign x_src[1]  = x_ff[i-1][1];
         assign y_src[0]  = y_ff[i-1][0];
         assign y_src[1]  = y_ff[i-1][1];
         assign z_src[0]  = z_ff[i-1][0];
         assign z_src[1]  = z_ff[i-1][1];
         assign valid_src = valid_ff[i-1];
         assign side_src  = side_ff[i-1];
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            if (!z_src[l][33]) begin
               x_in[l] = x_src[l] - (y_src[l] >>> i);
               y_in[l] = y_src[l] + (x_src[l] >>> i);
               z_in[l] = z_src[l] - ANG;
            end else begin
               x_in[l] = x_src[l] + (y_src[l] >>> i);
               y_in[l] = y_src[l] - (x_src[l] >>> i);
               z_in[l] = z_src[l] + ANG;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 2; l++) begin
               x_ff[i][l] <= x_in[l];
               y_ff[i][l] <= y_in[l];
               z_ff[i][l] <= z_in[l];
            end
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_sin0  = y_ff[N-1][0];
   assign out_sin1  = y_ff[N-1][1];
   assign out_side  = side_ff[N-1];

endmodule

>>> hdl/qslerp_divide.sv
module qslerp_divide (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [33:0]   in_num0,
   input  logic signed [33:0]   in_num1,
   input  qslerp_pkg::side_type in_side,
   output logic                 out_valid,
   output logic [30:0]          out_k0,
   output logic [30:0]          out_k1,
   output qslerp_pkg::side_type out_side
);

   localparam int N = qslerp_pkg::DIV_STEPS;

   logic [N-1:0]         valid_ff;
   logic [32:0]          r_ff    [N][2];
   logic [30:0]          q_ff    [N][2];
   logic                 sat_ff  [N][2];
   logic                 zero_ff [N][2];
   qslerp_pkg::side_type side_ff [N];
   logic [30:0]          k_out   [2];

   for (genvar i = 0; i < N; i++) begin : g_step
      logic [32:0] r_src  [2];
      logic [30:0] q_src  [2];
      logic        sat_src [2];
      logic        zero_src[2];
      logic [32:0] r_in   [2];
      logic [30:0] q_in   [2];
      logic [32:0] shifted[2];
      logic [32:0] d;
      logic        valid_src;
      qslerp_pkg::side_type side_src;

      if (i == 0) begin : g_first
         logic signed [33:0] num [2];
         assign num[0] = in_num0;
         assign num[1] = in_num1;
         always_comb begin
            for (int l = 0; l < 2; l++) begin
               zero_src[l] = num[l][33] || (num[l] == '0);
               sat_src[l]  = {1'b0, num[l][32:0]} >= {2'b0, in_side.s30, 1'b0};
               r_src[l]    = num[l][32:0];
               q_src[l]    = '0;
            end
         end
         assign valid_src = in_valid;
         assign side_src  = in_side;
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < 2; l++) begin
               zero_src[l] = zero_ff[i-1][l];
               sat_src[l]  = sat_ff[i-1][l];
               r_src[l]    = r_ff[i-1][l];
               q_src[l]    = q_ff[i-1][l];
            end
         end
         assign valid_src = valid_ff[i-1];
         assign side_src  = side_ff[i-1];
      end

      assign d = {2'b0, side_src.s30};

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            shifted[l] = (i == 0) ? r_src[l] : {r_src[l][31:0], 1'b0};
            if (shifted[l] >= d) begin
               r_in[l] = shifted[l] - d;
               q_in[l] = {q_src[l][29:0], 1'b1};
            end else begin
               r_in[l] = shifted[l];
               q_in[l] = {q_src[l][29:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 2; l++) begin
               r_ff[i][l]    <= r_in[l];
               q_ff[i][l]    <= q_in[l];
               sat_ff[i][l]  <= sat_src[l];
               zero_ff[i][l] <= zero_src[l];
            end
            side_ff[i] <= side_src;
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (zero_ff[N-1][l]) begin
            k_out[l] = '0;
         end else if (sat_ff[N-1][l] || (q_ff[N-1][l] > qslerp_pkg::ONE30)) begin
            k_out[l] = qslerp_pkg::ONE30;
         end else begin
            k_out[l] = q_ff[N-1][l];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_k0    = k_out[0];
   assign out_k1    = k_out[1];
   assign out_side  = side_ff[N-1];

endmodule

>>> hdl/quaternion_slerp_unit.sv
// throughput: one item per cycle, set by the fully pipelined square root,
// cordic and divider stages; a held response stalls the whole pipeline
// reset clears every stage valid bit and loads the linear threshold with 16382
module quaternion_slerp_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (16 each), fraction (15), pad (1)
   input  logic [143:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // out_x, out_y, out_z, out_w (16 each)
   output logic [63:0]   rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [14:0]   csr_data
);

   localparam int F  = qslerp_pkg::FRAC_BITS;
   localparam int WB = qslerp_pkg::WB;
   localparam logic [33:0] ONE2F = 34'(1) << (2 * F);
   localparam logic [14:0] ONEF  = 15'(1) << F;

   logic en;
   logic [14:0] thr_ff;

   // stage 1
   logic               v1_ff;
   logic signed [31:0] prod1_ff [4];
   logic [3:0][15:0]   a1_ff;
   logic [3:0][15:0]   b1_ff;
   logic [14:0]        frac1_ff;

   // stage 2
   logic                 v2_ff;
   qslerp_pkg::side_type side2_ff, side2_in;
   logic signed [33:0]   dot;
   logic [33:0]          dabs, dclamp;
   logic                 neg;
   logic [14:0]          tc;

   // stage 3
   logic                 v3_ff;
   logic [61:0]          sq3_ff;
   qslerp_pkg::side_type side3_ff;
   logic [60:0]          rad;

   logic                 sq_valid;
   logic [30:0]          sq_root;
   qslerp_pkg::side_type sq_side, vec_side_in;

   logic                 vec_valid;
   logic signed [32:0]   omega;
   qslerp_pkg::side_type vec_side;

   logic                 va_ff;
   logic signed [65:0]   m0_ff, m1_ff;
   qslerp_pkg::side_type sidea_ff;

   logic                 rot_valid;
   logic signed [33:0]   sin0, sin1;
   qslerp_pkg::side_type rot_side;

   logic                 div_valid;
   logic [30:0]          k0s, k1s;
   qslerp_pkg::side_type div_side;

   logic                 vb_ff;
   logic [30:0]          k0, k1;
   logic signed [47:0]   pa_ff [4];
   logic signed [48:0]   pb_ff [4];

   logic                 vc_ff;
   logic [3:0][15:0]     res_ff, res_in;

   assign en         = !vc_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 15'(qslerp_pkg::THR_RESET);
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         va_ff <= vec_valid;
         vb_ff <= div_valid;
         vc_ff <= vb_ff;
      end
   end

   // dot product terms
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            prod1_ff[i] <= $signed(req_tdata[16*i +: 16]) * $signed(req_tdata[64+16*i +: 16]);
            a1_ff[i]    <= req_tdata[16*i +: 16];
            b1_ff[i]    <= req_tdata[64+16*i +: 16];
         end
         frac1_ff <= req_tdata[142:128];
      end
   end

   // sum, short arc, threshold test, cosine and fraction clamp
   always_comb begin
      dot = '0;
      for (int i = 0; i < 4; i++) begin
         dot = dot + 34'(prod1_ff[i]);
      end
      neg    = dot[33];
      dabs   = neg ? 34'(-dot) : 34'(dot);
      dclamp = (dabs > ONE2F) ? ONE2F : dabs;
      tc     = (frac1_ff > ONEF) ? ONEF : frac1_ff;
      side2_in.a = a1_ff;
      for (int i = 0; i < 4; i++) begin
         side2_in.b[i] = neg ? 17'(-$signed({b1_ff[i][15], b1_ff[i]}))
                             : {b1_ff[i][15], b1_ff[i]};
      end
      side2_in.t30     = 31'(tc) << (WB - F);
      side2_in.use_lin = dabs > (34'(thr_ff) << F);
      side2_in.c30     = 31'(dclamp << (WB - 2 * F));
      side2_in.s30     = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff <= side2_in;
         side3_ff <= side2_ff;
         sq3_ff   <= side2_ff.c30 * side2_ff.c30;
      end
   end

   assign rad = 61'((62'(1) << (2 * WB)) - sq3_ff);

   qslerp_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_rad    (rad),
      .in_side   (side3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_comb begin
      vec_side_in         = sq_side;
      vec_side_in.s30     = sq_root;
      vec_side_in.use_lin = sq_side.use_lin || (sq_root == '0);
   end

   qslerp_cordic_vec u_vec (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_x      ({3'b0, sq_side.c30}),
      .in_y      ({3'b0, sq_root}),
      .in_side   (vec_side_in),
      .out_valid (vec_valid),
      .out_angle (omega),
      .out_side  (vec_side)
   );

   // split angle
   always_ff @(posedge clock) begin
      if (en) begin
         m0_ff    <= $signed({2'b0, qslerp_pkg::ONE30 - vec_side.t30}) * omega;
         m1_ff    <= $signed({2'b0, vec_side.t30}) * omega;
         sidea_ff <= vec_side;
      end
   end

   qslerp_cordic_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (va_ff),
      .in_z0     (m0_ff[63:30]),
      .in_z1     (m1_ff[63:30]),
      .in_side   (sidea_ff),
      .out_valid (rot_valid),
      .out_sin0  (sin0),
      .out_sin1  (sin1),
      .out_side  (rot_side)
   );

   qslerp_divide u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rot_valid),
      .in_num0   (sin0),
      .in_num1   (sin1),
      .in_side   (rot_side),
      .out_valid (div_valid),
      .out_k0    (k0s),
      .out_k1    (k1s),
      .out_side  (div_side)
   );

   assign k0 = div_side.use_lin ? (qslerp_pkg::ONE30 - div_side.t30) : k0s;
   assign k1 = div_side.use_lin ? div_side.t30 : k1s;

   // weighted components
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            pa_ff[i] <= $signed(div_side.a[i]) * $signed({1'b0, k0});
            pb_ff[i] <= $signed(div_side.b[i]) * $signed({1'b0, k1});
         end
      end
   end

   // round and saturate
   always_comb begin
      logic signed [49:0] sum;
      logic signed [19:0] r;
      for (int i = 0; i < 4; i++) begin
         sum = 50'(pa_ff[i]) + 50'(pb_ff[i]) + (50'sd1 <<< (WB - 1));
         r   = 20'(sum >>> WB);
         if (r > 20'sd32767) begin
            res_in[i] = 16'h7fff;
         end else if (r < -20'sd32768) begin
            res_in[i] = 16'h8000;
         end else begin
            res_in[i] = r[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = vc_ff;
   assign rsp_tdata  = res_ff;

endmodule

>>> tb/tb_quaternion_slerp_unit.sv
module tb_quaternion_slerp_unit;

   localparam int LATENCY = 128;
   localparam int WATCHDOG_LIMIT = 5000;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [143:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [63:0]   rsp_tdata;
   logic          csr_valid;
   logic          csr_ready;
   logic [14:0]   csr_data;

   quaternion_slerp_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   logic [63:0] expected_outputs[$];
   logic [14:0] threshold_model;
   int          error_count;
   int          idle_cycles;
   bit          idling_on;

   longint atan_steps[30] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2};

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint vector_angle(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_steps[i];
         end else begin
            x -= dx; y += dy; z -= atan_steps[i];
         end
      end
      return z;
   endfunction

   function automatic longint rotate_sine(longint z);
      longint x, y, dx, dy;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_steps[i];
         end else begin
            x += dx; y -= dy; z += atan_steps[i];
         end
      end
      return y;
   endfunction

   function automatic longint arc_weight(longint s, longint sin_w);
      longint k;
      k = (s * (64'sd1 << 30)) / sin_w;
      if (k < 0) k = 0;
      if (k > (64'sd1 << 30)) k = 64'sd1 << 30;
      return k;
   endfunction

   function automatic logic [63:0] slerp_predict(logic [143:0] d);
      longint a[4], b[4], dot, k0, k1, t, t30, c30, s30, omega, r, one30;
      logic [63:0] res;
      one30 = 64'sd1 << 30;
      dot = 0;
      for (int i = 0; i < 4; i++) begin
         a[i] = longint'($signed(d[16*i +: 16]));
         b[i] = longint'($signed(d[64 + 16*i +: 16]));
         dot += a[i] * b[i];
      end
      if (dot < 0) begin
         for (int i = 0; i < 4; i++) b[i] = -b[i];
         dot = -dot;
      end
      t = longint'(d[142:128]);
      if (t > 16384) t = 16384;
      t30 = t << 16;
      k0 = one30 - t30;
      k1 = t30;
      if (dot <= longint'(threshold_model) * 16384) begin
         if (dot > (64'sd1 << 28)) dot = 64'sd1 << 28;
         c30 = dot << 2;
         s30 = longint'(int_sqrt((64'd1 << 60) - longint'(c30 * c30)));
         if (s30 > 0) begin
            omega = vector_angle(c30, s30);
            k0 = arc_weight(rotate_sine(((one30 - t30) * omega) >>> 30), s30);
            k1 = arc_weight(rotate_sine((t30 * omega) >>> 30), s30);
         end
      end
      for (int i = 0; i < 4; i++) begin
         r = (a[i] * k0 + b[i] * k1 + (64'sd1 << 29)) >>> 30;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         res[16*i +: 16] = r[15:0];
      end
      return res;
   endfunction

   function automatic logic [143:0] pack_item(logic [15:0] q[8], logic [14:0] frac);
      logic [143:0] d;
      d = '0;
      for (int i = 0; i < 8; i++) d[16*i +: 16] = q[i];
      d[142:128] = frac;
      return d;
   endfunction

   task automatic report_mismatch(string field, logic [15:0] exp_v, logic [15:0] got_v);
      $display("mismatch %s: expected %0d got %0d", field,
               $signed(exp_v), $signed(got_v));
      error_count++;
   endtask

   // sends one item, leaves req_tvalid high after acceptance
   task automatic send_item(logic [143:0] d);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_tvalid = 0;
         repeat ($urandom_range(1, 10) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1;
      req_tdata = d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_outputs.push_back(slerp_predict(d));
   endtask

   task automatic drain_pipeline;
      @(negedge clock);
      req_tvalid = 0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_threshold(logic [14:0] value);
      drain_pipeline();
      @(negedge clock);
      csr_valid = 1;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      threshold_model = value;
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic logic [143:0] random_item();
      logic [15:0] q[8];
      logic [14:0] frac;
      int mode;
      mode = $urandom_range(0, 9);
      frac = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
      if (mode == 0) begin
         for (int i = 0; i < 8; i++) q[i] = 16'($urandom);
      end else begin
         // pair with b a perturbed copy of a (b random in mode 1), flipped in modes 7 to 9
         for (int i = 0; i < 4; i++) begin
            q[i] = 16'($signed($urandom_range(0, 16384)) - 8192);
            q[i + 4] = q[i] + 16'($signed($urandom_range(0, 1 << $urandom_range(0, 13)))
                       - ($signed($urandom_range(0, 1 << $urandom_range(0, 13)))));
            if (mode == 1) q[i + 4] = 16'($urandom);
         end
         if (mode >= 7) for (int i = 4; i < 8; i++) q[i] = -q[i];
      end
      return pack_item(q, frac);
   endfunction

   task automatic test_directed;
      logic [15:0] q[8];
      logic [15:0] vals[4] = '{16'h8000, 16'h7fff, 16'h4000, 16'h0000};
      logic [14:0] fracs[5] = '{15'd0, 15'd16384, 15'd8192, 15'h7fff, 15'd1};
      for (int v = 0; v < 4; v++)
         for (int f = 0; f < 5; f++) begin
            for (int i = 0; i < 8; i++) q[i] = (i == 3 || i == 7) ? vals[v] : 16'h0;
            if (f == 2) q[7] = -vals[v];
            send_item(pack_item(q, fracs[f]));
         end
      // orthogonal unit quaternions, opposite ones, and unequal lengths
      q = '{16'h4000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0};
      send_item(pack_item(q, 15'd4096));
      q = '{16'h2d41, 16'h2d41, 16'h0, 16'h0, 16'hd2bf, 16'hd2bf, 16'h0, 16'h0100};
      send_item(pack_item(q, 15'd12288));
      q = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7000};
      send_item(pack_item(q, 15'd5000));
      q = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
      send_item(pack_item(q, 15'd9000));
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) send_item(random_item());
   endtask

   task automatic test_thresholds;
      logic [14:0] settings[5] = '{15'd0, 15'd16384, 15'h7fff, 15'd16000, 15'd16383};
      for (int s = 0; s < 5; s++) begin
         write_threshold(settings[s]);
         test_directed();
         test_random(150);
      end
      write_threshold(15'd16382);
   endtask

   // response back-pressure in bursts
   initial begin
      rsp_tready = 1;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_tready = 0;
            repeat ($urandom_range(1, 10) - 1) @(negedge clock);
            @(negedge clock);
         end
         rsp_tready = 1;
         repeat ($urandom_range(0, 9)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outputs.size() == 0) begin
            $display("unexpected output item %h", rsp_tdata);
            error_count++;
         end else begin
            logic [63:0] e;
            e = expected_outputs.pop_front();
            if (e[15:0] !== rsp_tdata[15:0]) report_mismatch("out_x", e[15:0], rsp_tdata[15:0]);
            if (e[31:16] !== rsp_tdata[31:16])
               report_mismatch("out_y", e[31:16], rsp_tdata[31:16]);
            if (e[47:32] !== rsp_tdata[47:32])
               report_mismatch("out_z", e[47:32], rsp_tdata[47:32]);
            if (e[63:48] !== rsp_tdata[63:48])
               report_mismatch("out_w", e[63:48], rsp_tdata[63:48]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** quaternion_slerp_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_valid = 0;
      csr_data = '0;
      error_count = 0;
      idle_cycles = 0;
      idling_on = 1;
      threshold_model = 15'(qslerp_pkg::THR_RESET);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_random(110);
      test_thresholds();
      idling_on = 0;
      test_random(150);
      drain_pipeline();
      if (error_count == 0) begin
         $display("** quaternion_slerp_unit: PASSED **");
      end else begin
         $display("** quaternion_slerp_unit: FAILED **");
      end
      $finish;
   end

endmodule
